@@ hw/rtl/mi3_pkg.sv @@
// shared types and constants for the 3x3 matrix inverse
// no dependencies
package mi3_pkg;

   localparam int DATA_W      = 32;
   localparam int N_ELEM      = 9;
   localparam int ADJ_W       = 64;
   localparam int DET_W       = 97;
   localparam int NUM_W       = 98;
   localparam int DIV_STEPS   = 35;
   localparam int QUO_W       = DIV_STEPS;
   localparam int REM_W       = NUM_W + DIV_STEPS - 1;
   localparam int FRONT_DEPTH = 6;
   localparam int QUEUE_DEPTH = 16;

   localparam logic [DATA_W-1:0] THR_RESET = 32'd1;
   localparam logic [DATA_W-1:0] SAT_POS   = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] SAT_NEG   = 32'h8000_0000;

   // one classified matrix handed from the front end to the divider
   typedef struct packed {
      logic [N_ELEM-1:0][ADJ_W-1:0] adj;
      logic [DET_W-1:0]             dmag;
      logic                         dneg;
      logic                         sing;
   } front_item_type;

endpackage

@@ hw/rtl/mi3_front.sv @@
// front end: cofactors, determinant, magnitude and singular test
// depends on mi3_pkg
module mi3_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [mi3_pkg::N_ELEM*mi3_pkg::DATA_W-1:0] in_data,
   input  logic [mi3_pkg::DATA_W-1:0]        thr,
   output logic                              out_valid,
   output mi3_pkg::front_item_type           out_item,
   output logic [$clog2(mi3_pkg::FRONT_DEPTH+1)-1:0] occupancy
);
   import mi3_pkg::*;

   localparam int OCC_W = $clog2(FRONT_DEPTH + 1);

   logic signed [DATA_W-1:0] mm [N_ELEM];
   logic signed [ADJ_W-1:0]  pa_in [N_ELEM], pb_in [N_ELEM];
   logic signed [ADJ_W-1:0]  pa_ff [N_ELEM], pb_ff [N_ELEM];
   logic signed [DATA_W-1:0] m0_1_ff [3], m0_2_ff [3];
   logic signed [ADJ_W-1:0]  adj2_ff [N_ELEM], adj3_ff [N_ELEM], adj4_ff [N_ELEM];
   logic signed [ADJ_W-1:0]  adj5_ff [N_ELEM], adj6_ff [N_ELEM];
   logic signed [ADJ_W:0]    plo_ff [3];
   logic signed [ADJ_W-1:0]  phi_ff [3];
   logic signed [DET_W-1:0]  term_ff [3];
   logic signed [DET_W-1:0]  det_ff;
   logic [DET_W-1:0]         dmag_ff;
   logic                     dneg_ff;
   logic [FRONT_DEPTH-1:0]   vld_ff;

   always_comb begin
      for (int i = 0; i < N_ELEM; i++) begin
         mm[i] = $signed(in_data[i*DATA_W +: DATA_W]);
      end
      pa_in[0] = mm[4] * mm[8];  pb_in[0] = mm[7] * mm[5];
      pa_in[1] = mm[2] * mm[7];  pb_in[1] = mm[1] * mm[8];
      pa_in[2] = mm[1] * mm[5];  pb_in[2] = mm[2] * mm[4];
      pa_in[3] = mm[5] * mm[6];  pb_in[3] = mm[3] * mm[8];
      pa_in[4] = mm[0] * mm[8];  pb_in[4] = mm[6] * mm[2];
      pa_in[5] = mm[3] * mm[2];  pb_in[5] = mm[0] * mm[5];
      pa_in[6] = mm[3] * mm[7];  pb_in[6] = mm[6] * mm[4];
      pa_in[7] = mm[6] * mm[1];  pb_in[7] = mm[0] * mm[7];
      pa_in[8] = mm[0] * mm[4];  pb_in[8] = mm[3] * mm[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[FRONT_DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N_ELEM; i++) begin
         pa_ff[i]   <= pa_in[i];
         pb_ff[i]   <= pb_in[i];
         adj2_ff[i] <= pa_ff[i] - pb_ff[i];
         adj3_ff[i] <= adj2_ff[i];
         adj4_ff[i] <= adj3_ff[i];
         adj5_ff[i] <= adj4_ff[i];
         adj6_ff[i] <= adj5_ff[i];
      end
      for (int t = 0; t < 3; t++) begin
         m0_1_ff[t] <= mm[t];
         m0_2_ff[t] <= m0_1_ff[t];
         // split the 64-bit operand into two 32-bit halves for two partial products
         plo_ff[t]  <= m0_2_ff[t] * $signed({1'b0, adj2_ff[t*3][DATA_W-1:0]});
         phi_ff[t]  <= m0_2_ff[t] * $signed(adj2_ff[t*3][ADJ_W-1:DATA_W]);
         term_ff[t] <= $signed({phi_ff[t][ADJ_W-1], phi_ff[t], {DATA_W{1'b0}}})
                     + $signed({{(DET_W-ADJ_W-1){plo_ff[t][ADJ_W]}}, plo_ff[t]});
      end
      det_ff  <= term_ff[0] + term_ff[1] + term_ff[2];
      dneg_ff <= det_ff[DET_W-1];
      dmag_ff <= det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
   end

   always_comb begin
      for (int i = 0; i < N_ELEM; i++) begin
         out_item.adj[i] = adj6_ff[i];
      end
      out_item.dmag = dmag_ff;
      out_item.dneg = dneg_ff;
      out_item.sing = dmag_ff <= {{(DET_W-2*DATA_W){1'b0}}, thr, {DATA_W{1'b0}}};
   end

   assign out_valid = vld_ff[FRONT_DEPTH-1];
   assign occupancy = OCC_W'($countones(vld_ff));

endmodule

@@ hw/rtl/mi3_queue.sv @@
// small fifo between front end and divider
// depends on mi3_pkg
module mi3_queue #(
   parameter int DEPTH = mi3_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  mi3_pkg::front_item_type   wr_data,
   input  logic                      rd_en,
   output mi3_pkg::front_item_type   rd_data,
   output logic                      empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import mi3_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   front_item_type    mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(wr_en) - CNT_W'(rd_en);
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign count   = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff != CNT_W'(DEPTH)))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (count_ff != '0))
      else $error("queue read while empty");

endmodule

@@ hw/rtl/mi3_back.sv @@
// back end: restoring division pipeline, rounding, saturation, singular zeroing, output register
// depends on mi3_pkg
module mi3_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  mi3_pkg::front_item_type           in_item,
   output logic                              pop,
   input  logic                              out_ready,
   output logic                              out_valid,
   output logic [mi3_pkg::N_ELEM*mi3_pkg::DATA_W-1:0] out_data,
   output logic                              out_sing
);
   import mi3_pkg::*;

   localparam int NS = DIV_STEPS;

   logic                     en;
   logic [REM_W-1:0]         rem_ff [NS+1][N_ELEM];
   logic [QUO_W-1:0]         quo_ff [NS+1][N_ELEM];
   logic [N_ELEM-1:0]        neg_ff [NS+1];
   logic [NUM_W-1:0]         den_ff [NS+1];
   logic                     sing_ff [NS+1];
   logic [NS:0]              vld_ff;
   logic [REM_W-1:0]         rem_in [NS+1][N_ELEM];
   logic [QUO_W-1:0]         quo_in [NS+1][N_ELEM];
   logic [N_ELEM-1:0]        neg0_in;
   logic [ADJ_W-1:0]         mag;
   logic [REM_W-1:0]         dsh;
   logic                     ge;
   logic [DATA_W-1:0]        qm;
   logic                     big;
   logic [N_ELEM*DATA_W-1:0] res_in;
   logic                     out_valid_ff;
   logic [N_ELEM*DATA_W-1:0] out_data_ff;
   logic                     out_sing_ff;

   assign en  = !out_valid_ff || out_ready;
   assign pop = en && in_valid;

   always_comb begin
      // prepare numerator 2*|adj|*2^32 + |det| for round-half-up
      for (int e = 0; e < N_ELEM; e++) begin
         mag = in_item.adj[e][ADJ_W-1] ? ADJ_W'(-in_item.adj[e]) : in_item.adj[e];
         rem_in[0][e] = REM_W'({1'b0, mag, {(DATA_W+1){1'b0}}})
                      + REM_W'(in_item.dmag);
         quo_in[0][e] = '0;
         neg0_in[e]   = in_item.adj[e][ADJ_W-1] ^ in_item.dneg;
      end
      // one quotient bit per stage, most significant first
      for (int s = 0; s < NS; s++) begin
         for (int e = 0; e < N_ELEM; e++) begin
            dsh = REM_W'(den_ff[s]) << (NS - 1 - s);
            ge  = rem_ff[s][e] >= dsh;
            rem_in[s+1][e] = ge ? rem_ff[s][e] - dsh : rem_ff[s][e];
            quo_in[s+1][e] = quo_ff[s][e] | (QUO_W'(ge) << (NS - 1 - s));
         end
      end
      for (int e = 0; e < N_ELEM; e++) begin
         big = (quo_ff[NS][e][QUO_W-1:DATA_W] != '0)
            || (quo_ff[NS][e][DATA_W-1:0] > SAT_NEG);
         qm  = big ? SAT_NEG : quo_ff[NS][e][DATA_W-1:0];
         priority if (sing_ff[NS]) begin
            res_in[e*DATA_W +: DATA_W] = '0;
         end else if (neg_ff[NS][e]) begin
            res_in[e*DATA_W +: DATA_W] = DATA_W'(-qm);
         end else begin
            res_in[e*DATA_W +: DATA_W] = qm[DATA_W-1] ? SAT_POS : qm;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[NS-1:0], in_valid};
         out_valid_ff <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int e = 0; e < N_ELEM; e++) begin
            rem_ff[0][e] <= rem_in[0][e];
            quo_ff[0][e] <= quo_in[0][e];
         end
         neg_ff[0]  <= neg0_in;
         den_ff[0]  <= {in_item.dmag, 1'b0};
         sing_ff[0] <= in_item.sing;
         for (int s = 1; s <= NS; s++) begin
            for (int e = 0; e < N_ELEM; e++) begin
               rem_ff[s][e] <= rem_in[s][e];
               quo_ff[s][e] <= quo_in[s][e];
            end
            neg_ff[s]  <= neg_ff[s-1];
            den_ff[s]  <= den_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
         end
         out_data_ff <= res_in;
         out_sing_ff <= sing_ff[NS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_sing  = out_sing_ff;

endmodule

@@ hw/rtl/matrix3x3_inverse.sv @@
// 3x3 matrix inverse, signed q16.16, adjugate over determinant
// a request passes the front-end pipeline, the queue, the divider pipeline and the output register to rsp_tvalid
// throughput one matrix per cycle while rsp_tready stays high, set by the 35-stage divider advancing unless stalled
// reset clears all valid bits, queue pointers and sets singular_threshold to 1
// depends on mi3_pkg, mi3_front, mi3_queue, mi3_back
module matrix3x3_inverse #(
   parameter int QDEPTH = mi3_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // a00 a01 a02 a10 a11 a12 a20 a21 a22, 32 bits each from bit 0 up
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mi3_pkg::N_ELEM*mi3_pkg::DATA_W-1:0] req_tdata,
   // b00 b01 b02 b10 b11 b12 b20 b21 b22, 32 bits each from bit 0 up
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mi3_pkg::N_ELEM*mi3_pkg::DATA_W-1:0] rsp_tdata,
   // singular
   output logic                          rsp_tuser,
   // singular_threshold write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mi3_pkg::DATA_W-1:0]    csr_data
);
   import mi3_pkg::*;

   localparam int OCC_W = $clog2(FRONT_DEPTH + 1);
   localparam int CNT_W = $clog2(QDEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [DATA_W-1:0] thr_ff;
   logic              req_xfer;
   logic              push, pop, q_empty;
   front_item_type    push_item, head_item;
   logic [OCC_W-1:0]  occ;
   logic [CNT_W-1:0]  q_count;
   logic [SUM_W-1:0]  credit_used;

   // threshold register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // front never stalls: take an item only when a queue slot is reserved for it
   assign credit_used = SUM_W'(occ) + SUM_W'(q_count);
   assign req_tready  = credit_used < SUM_W'(QDEPTH);
   assign req_xfer    = req_tvalid && req_tready;

   mi3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_xfer),
      .in_data   (req_tdata),
      .thr       (thr_ff),
      .out_valid (push),
      .out_item  (push_item),
      .occupancy (occ)
   );

   // decouples the front end from divider stalls
   mi3_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (push_item),
      .rd_en   (pop),
      .rd_data (head_item),
      .empty   (q_empty),
      .count   (q_count)
   );

   // divider pipeline stalls as a whole while the output register is held
   mi3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_item   (head_item),
      .pop       (pop),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_sing  (rsp_tuser)
   );

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_used <= SUM_W'(QDEPTH))
      else $error("front end and queue hold more items than reserved");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("singular result carries nonzero elements");

endmodule
